>>> rtl/core/chained_hash_table_engine_macros.svh
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chained hash table engine check failed");

// Next-cycle implication, checked outside reset.
`define CHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chained hash table engine check failed");

`endif

>>> rtl/core/chte_pkg.sv
package chte_pkg;

    localparam int BUCKETS        = 1024;
    localparam int OVERFLOW_DEPTH = 1024;
    localparam int KEY_BITS       = 32;
    localparam int PAYLOAD_BITS   = 32;
    localparam int MAX_OUT        = 64;

    localparam int BUCKET_AW  = $clog2(BUCKETS);
    localparam int SLOT_TOTAL = BUCKETS + OVERFLOW_DEPTH;
    localparam int SLOT_AW    = $clog2(SLOT_TOTAL);
    localparam int LINK_W     = $clog2(OVERFLOW_DEPTH);
    localparam int OCNT_W     = $clog2(OVERFLOW_DEPTH + 1);
    localparam int NOUT_W     = $clog2(MAX_OUT);
    localparam int LB_W       = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] CFG_LOG_BUCKETS = 2'd0;
    localparam logic [1:0] CFG_MULTI_MATCH = 2'd1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_MATCH    = 2'd1,
        STAT_NO_MORE  = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HEAD  = 6'b000100,
        S_CHK   = 6'b001000,
        S_LINK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                    link_valid;
        logic [LINK_W-1:0]       link;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } slot_t;

endpackage

>>> rtl/core/chte_ram.sv
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/chained_hash_table_engine.sv
// Chained hash table engine with a bucket array and an overflow area.
// Input words (s_*) carry an insert (func 0) or a lookup (func 1) with a
// precomputed hash, a key and a payload. Result words (m_*) follow; an
// insert gives one word, a lookup gives one word per match and then a
// done word, and the final word of every input carries m_last.
// Configuration words on cfg_* set log_buckets (index 0) and multi_match
// (index 1); other indexes are ignored. Write them only while idle.
// After reset the block clears its bucket flags, one per cycle, and
// s_ready stays low until all 1024 are clear. An insert loads its result
// word into the output register in the check state if its bucket is
// free or the overflow area is full, and in the link state if it is
// taken. A lookup checks the head in the check state, where a match
// loads its word, and goes back through the head and check states for
// each chain entry it follows, since the slot memory has a single
// registered read port; the done state then loads the done word. One
// input is in flight at a time; the next is taken in the cycle after the
// last result word is loaded into the output register. When the receiver
// stalls, the walk holds until the output register frees, so no word is lost.
`include "chained_hash_table_engine_macros.svh"

module chained_hash_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_hash,
    input  logic [31:0] s_key,
    input  logic [31:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_payload_out,
    output logic        m_last,
    output logic        m_truncated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    chte_pkg::state_t state_reg, state_next;
    logic [chte_pkg::BUCKET_AW-1:0] clr_reg, clr_next;
    logic [chte_pkg::BUCKET_AW-1:0] bkt_reg, bkt_next;
    logic [chte_pkg::SLOT_AW-1:0]   cur_reg, cur_next;
    logic                           func_reg, func_next;
    logic [chte_pkg::KEY_BITS-1:0]  key_reg, key_next;
    logic [chte_pkg::PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [chte_pkg::OCNT_W-1:0]    ocnt_reg, ocnt_next;
    logic [chte_pkg::NOUT_W-1:0]    n_reg, n_next;
    logic                           trunc_reg, trunc_next;
    logic [chte_pkg::LB_W-1:0]      lb_reg, lb_next;
    logic                           multi_reg, multi_next;

    logic                           m_valid_reg, m_valid_next;
    chte_pkg::status_t              m_status_reg, m_status_next;
    logic [31:0]                    m_pay_reg, m_pay_next;
    logic                           m_last_reg, m_last_next;
    logic                           m_trunc_reg, m_trunc_next;

    logic                           bu_we, bu_wdata, bu_rdata;
    logic [chte_pkg::BUCKET_AW-1:0] bu_waddr;
    logic                           slot_we;
    logic [chte_pkg::SLOT_AW-1:0]   slot_waddr;
    chte_pkg::slot_t                slot_wdata, slot_rdata;

    logic                           out_free, accept;
    logic [chte_pkg::LB_W-1:0]      lb_eff;
    logic [chte_pkg::BUCKET_AW-1:0] bmask, in_bkt;
    logic [chte_pkg::SLOT_AW-1:0]   ovf_addr, link_addr;

    chte_ram #(.WIDTH(1), .DEPTH(chte_pkg::BUCKETS)) u_bucket_ram (
        .aclk  (aclk),
        .we    (bu_we),
        .waddr (bu_waddr),
        .wdata (bu_wdata),
        .raddr (bkt_reg),
        .rdata (bu_rdata)
    );

    chte_ram #(.WIDTH($bits(chte_pkg::slot_t)), .DEPTH(chte_pkg::SLOT_TOTAL)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (cur_reg),
        .rdata (slot_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == chte_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign lb_eff    = (lb_reg == '0) ? chte_pkg::LB_W'(1) : lb_reg;

    always_comb begin
        for (int i = 0; i < chte_pkg::BUCKET_AW; i++) begin
            bmask[i] = (i < int'(lb_eff));
        end
    end

    assign in_bkt    = s_hash[chte_pkg::BUCKET_AW-1:0] & bmask;
    assign ovf_addr  = chte_pkg::SLOT_AW'(chte_pkg::BUCKETS) + chte_pkg::SLOT_AW'(ocnt_reg);
    assign link_addr = chte_pkg::SLOT_AW'(chte_pkg::BUCKETS)
                     + chte_pkg::SLOT_AW'(slot_rdata.link);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        bkt_next      = bkt_reg;
        cur_next      = cur_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        ocnt_next     = ocnt_reg;
        n_next        = n_reg;
        trunc_next    = trunc_reg;
        lb_next       = lb_reg;
        multi_next    = multi_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_pay_next    = m_pay_reg;
        m_last_next   = m_last_reg;
        m_trunc_next  = m_trunc_reg;
        bu_we         = 1'b0;
        bu_waddr      = bkt_reg;
        bu_wdata      = 1'b0;
        slot_we       = 1'b0;
        slot_waddr    = cur_reg;
        slot_wdata    = '{link_valid: 1'b0, link: '0, key: key_reg, payload: pay_reg};

        if (cfg_valid) begin
            case (cfg_index)
                chte_pkg::CFG_LOG_BUCKETS: lb_next = cfg_data;
                chte_pkg::CFG_MULTI_MATCH: multi_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            chte_pkg::S_CLEAR: begin
                bu_we    = 1'b1;
                bu_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == chte_pkg::BUCKET_AW'(chte_pkg::BUCKETS - 1)) begin
                    state_next = chte_pkg::S_IDLE;
                end
            end
            chte_pkg::S_IDLE: begin
                if (accept) begin
                    func_next  = s_func;
                    key_next   = s_key;
                    pay_next   = s_payload;
                    bkt_next   = in_bkt;
                    cur_next   = chte_pkg::SLOT_AW'(in_bkt);
                    n_next     = '0;
                    trunc_next = 1'b0;
                    state_next = chte_pkg::S_HEAD;
                end
            end
            chte_pkg::S_HEAD: begin
                state_next = chte_pkg::S_CHK;
            end
            chte_pkg::S_CHK: begin
                if (out_free) begin
                    if (func_reg == chte_pkg::FUNC_INSERT) begin
                        m_valid_next  = 1'b1;
                        m_status_next = chte_pkg::STAT_INSERTED;
                        m_pay_next    = '0;
                        m_last_next   = 1'b1;
                        m_trunc_next  = 1'b0;
                        state_next    = chte_pkg::S_IDLE;
                        if (!bu_rdata) begin
                            bu_we    = 1'b1;
                            bu_wdata = 1'b1;
                            slot_we  = 1'b1;
                        end else if (ocnt_reg == chte_pkg::OCNT_W'(chte_pkg::OVERFLOW_DEPTH)) begin
                            m_status_next = chte_pkg::STAT_FULL;
                        end else begin
                            m_valid_next = 1'b0;
                            slot_we      = 1'b1;
                            slot_waddr   = ovf_addr;
                            slot_wdata   = '{link_valid: slot_rdata.link_valid,
                                             link: slot_rdata.link,
                                             key: key_reg, payload: pay_reg};
                            state_next   = chte_pkg::S_LINK;
                        end
                    end else if (!bu_rdata) begin
                        state_next = chte_pkg::S_DONE;
                    end else if (slot_rdata.key == key_reg &&
                                 n_reg == chte_pkg::NOUT_W'(chte_pkg::MAX_OUT - 1)) begin
                        trunc_next = 1'b1;
                        state_next = chte_pkg::S_DONE;
                    end else begin
                        if (slot_rdata.key == key_reg) begin
                            m_valid_next  = 1'b1;
                            m_status_next = chte_pkg::STAT_MATCH;
                            m_pay_next    = slot_rdata.payload;
                            m_last_next   = 1'b0;
                            m_trunc_next  = 1'b0;
                            n_next        = n_reg + 1'b1;
                        end
                        if (slot_rdata.key == key_reg && !multi_reg) begin
                            state_next = chte_pkg::S_DONE;
                        end else if (slot_rdata.link_valid) begin
                            cur_next   = link_addr;
                            state_next = chte_pkg::S_HEAD;
                        end else begin
                            state_next = chte_pkg::S_DONE;
                        end
                    end
                end
            end
            chte_pkg::S_LINK: begin
                slot_we       = 1'b1;
                slot_wdata    = '{link_valid: 1'b1,
                                  link: chte_pkg::LINK_W'(ocnt_reg),
                                  key: slot_rdata.key, payload: slot_rdata.payload};
                ocnt_next     = ocnt_reg + 1'b1;
                m_valid_next  = 1'b1;
                m_status_next = chte_pkg::STAT_INSERTED;
                m_pay_next    = '0;
                m_last_next   = 1'b1;
                m_trunc_next  = 1'b0;
                state_next    = chte_pkg::S_IDLE;
            end
            chte_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = chte_pkg::STAT_NO_MORE;
                    m_pay_next    = '0;
                    m_last_next   = 1'b1;
                    m_trunc_next  = trunc_reg;
                    state_next    = chte_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = chte_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= chte_pkg::S_CLEAR;
            clr_reg     <= '0;
            ocnt_reg    <= '0;
            lb_reg      <= chte_pkg::LB_W'(10);
            multi_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            n_reg       <= '0;
            trunc_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ocnt_reg    <= ocnt_next;
            lb_reg      <= lb_next;
            multi_reg   <= multi_next;
            m_valid_reg <= m_valid_next;
            n_reg       <= n_next;
            trunc_reg   <= trunc_next;
        end
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        m_status_reg <= m_status_next;
        m_pay_reg    <= m_pay_next;
        m_last_reg   <= m_last_next;
        m_trunc_reg  <= m_trunc_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_payload_out = m_pay_reg;
    assign m_last        = m_last_reg;
    assign m_truncated   = m_trunc_reg;

    `CHTE_ASSERT_IMPL(a_ocnt_bound, aclk, aresetn, 1'b1,
        ocnt_reg <= chte_pkg::OCNT_W'(chte_pkg::OVERFLOW_DEPTH))
    `CHTE_ASSERT_IMPL(a_clear_blocks, aclk, aresetn,
        state_reg == chte_pkg::S_CLEAR, !s_ready && !m_valid_reg)
    `CHTE_ASSERT_IMPL(a_match_not_last, aclk, aresetn,
        m_valid_reg && m_status_reg == chte_pkg::STAT_MATCH, !m_last_reg && !m_trunc_reg)
    `CHTE_ASSERT_IMPL(a_nomatch_zero, aclk, aresetn,
        m_valid_reg && m_status_reg != chte_pkg::STAT_MATCH, m_pay_reg == '0 && m_last_reg)
    `CHTE_ASSERT_NEXT(a_link_counts, aclk, aresetn,
        state_reg == chte_pkg::S_LINK, ocnt_reg == $past(ocnt_reg) + 1'b1)

endmodule

>>> test/chained_hash_table_engine_test.sv
module chained_hash_table_engine_test;
    import chte_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [31:0] payload_out;
        logic        last;
        logic        truncated;
    } result_word_t;

    typedef struct {
        logic        func;
        logic [31:0] hash;
        logic [31:0] key;
        logic [31:0] payload;
        bit          typed;
        status_t     status;
    } probe_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [31:0] s_hash;
    logic [31:0] s_key;
    logic [31:0] s_payload;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_payload_out;
    logic        m_last;
    logic        m_truncated;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    // Shadow copy of the table contents and registers.
    bit                    head_taken [BUCKETS];
    logic [KEY_BITS-1:0]   entry_key [SLOT_TOTAL];
    logic [31:0]           entry_payload [SLOT_TOTAL];
    logic [LINK_W-1:0]     entry_link [SLOT_TOTAL];
    bit                    entry_linked [SLOT_TOTAL];
    int unsigned           overflow_used;
    logic [3:0]            shadow_log_buckets;
    logic                  shadow_multi_match;

    result_word_t pending_results[$];
    logic [31:0]  known_hashes[$];
    logic [31:0]  known_keys[$];

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;
    bit          failed;

    probe_row_t probe_rows[9];

    chained_hash_table_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_hash        (s_hash),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_payload_out (m_payload_out),
        .m_last        (m_last),
        .m_truncated   (m_truncated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned bucket_select(logic [31:0] hash);
        int unsigned lb;
        int unsigned idx;
        lb = shadow_log_buckets;
        if (lb < 1) begin
            lb = 1;
        end
        if (lb > 16) begin
            lb = 16;
        end
        idx = hash & ((32'd1 << lb) - 1);
        return idx % BUCKETS;
    endfunction

    function automatic void push_result(status_t status, logic [31:0] pay, logic last,
                                        logic trunc);
        result_word_t w;
        w.status      = status;
        w.payload_out = pay;
        w.last        = last;
        w.truncated   = trunc;
        pending_results.push_back(w);
    endfunction

    function automatic void hash_table_apply(logic func, logic [31:0] hash, logic [31:0] key,
                                             logic [31:0] pay);
        int unsigned b;
        int unsigned s;
        int unsigned steps;
        int unsigned n;
        bit          trunc;
        b = bucket_select(hash);
        if (func == FUNC_INSERT) begin
            if (!head_taken[b]) begin
                head_taken[b]    = 1'b1;
                entry_key[b]     = key;
                entry_payload[b] = pay;
                entry_link[b]    = '0;
                entry_linked[b]  = 1'b0;
                push_result(STAT_INSERTED, 32'd0, 1'b1, 1'b0);
            end else if (overflow_used >= OVERFLOW_DEPTH) begin
                push_result(STAT_FULL, 32'd0, 1'b1, 1'b0);
            end else begin
                s = BUCKETS + overflow_used;
                entry_key[s]     = key;
                entry_payload[s] = pay;
                entry_link[s]    = entry_link[b];
                entry_linked[s]  = entry_linked[b];
                entry_link[b]    = overflow_used;
                entry_linked[b]  = 1'b1;
                overflow_used++;
                push_result(STAT_INSERTED, 32'd0, 1'b1, 1'b0);
            end
            return;
        end
        n = 0;
        trunc = 1'b0;
        if (head_taken[b]) begin
            s = b;
            steps = 0;
            forever begin
                if (entry_key[s] == key) begin
                    if (n >= MAX_OUT - 1) begin
                        trunc = 1'b1;
                        break;
                    end
                    push_result(STAT_MATCH, entry_payload[s], 1'b0, 1'b0);
                    n++;
                    if (!shadow_multi_match) begin
                        break;
                    end
                end
                if (!entry_linked[s]) begin
                    break;
                end
                steps++;
                if (steps > OVERFLOW_DEPTH) begin
                    break;
                end
                s = BUCKETS + entry_link[s];
            end
        end
        push_result(STAT_NO_MORE, 32'd0, 1'b1, trunc);
    endfunction

    task automatic send_word(logic func, logic [31:0] hash, logic [31:0] key, logic [31:0] pay);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_hash    <= hash;
        s_key     <= key;
        s_payload <= pay;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_checked(logic func, logic [31:0] hash, logic [31:0] key,
                                logic [31:0] pay);
        send_word(func, hash, key, pay);
        hash_table_apply(func, hash, key, pay);
        if (func == FUNC_INSERT) begin
            known_hashes.push_back(hash);
            known_keys.push_back(key);
        end
    endtask

    task automatic write_register(logic [1:0] index, logic [3:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_LOG_BUCKETS) begin
            shadow_log_buckets = value;
        end else if (index == CFG_MULTI_MATCH) begin
            shadow_multi_match = value[0];
        end
    endtask

    task automatic random_traffic(int unsigned count);
        int unsigned pick;
        int unsigned r;
        logic [31:0] key;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45 || known_keys.size() == 0) begin
                key = $urandom;
                if (known_keys.size() != 0 && $urandom_range(99) < 30) begin
                    key = known_keys[$urandom_range(known_keys.size() - 1)];
                end
                send_checked(FUNC_INSERT, $urandom, key, $urandom);
            end else if (r < 90) begin
                pick = $urandom_range(known_keys.size() - 1);
                send_checked(FUNC_LOOKUP, known_hashes[pick], known_keys[pick], $urandom);
            end else begin
                send_checked(FUNC_LOOKUP, $urandom, $urandom, $urandom);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d payload_out %0h", m_status,
                       m_payload_out);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_status);
                    failed = 1'b1;
                end
                if (m_payload_out !== want.payload_out) begin
                    $error("payload_out expected %0h got %0h", want.payload_out, m_payload_out);
                    failed = 1'b1;
                end
                if (m_last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_last);
                    failed = 1'b1;
                end
                if (m_truncated !== want.truncated) begin
                    $error("truncated expected %0d got %0d", want.truncated, m_truncated);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_func    = FUNC_INSERT;
        s_hash    = '0;
        s_key     = '0;
        s_payload = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LOG_BUCKETS;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        failed = 1'b0;
        overflow_used = 0;
        shadow_log_buckets = 4'd10;
        shadow_multi_match = 1'b0;
        foreach (head_taken[i]) head_taken[i] = 1'b0;
        foreach (entry_linked[i]) entry_linked[i] = 1'b0;

        probe_rows[0] = '{FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 1, STAT_NO_MORE};
        probe_rows[1] = '{FUNC_INSERT, 32'h0, 32'h0, 32'h0, 1, STAT_INSERTED};
        probe_rows[2] = '{FUNC_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
                          STAT_INSERTED};
        probe_rows[3] = '{FUNC_INSERT, 32'h400, 32'h0, 32'h1234, 1, STAT_INSERTED};
        probe_rows[4] = '{FUNC_LOOKUP, 32'h0, 32'h0, 32'hFFFFFFFF, 0, STAT_NO_MORE};
        probe_rows[5] = '{FUNC_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 0, STAT_NO_MORE};
        probe_rows[6] = '{FUNC_LOOKUP, 32'h0, 32'h5, 32'h0, 1, STAT_NO_MORE};
        probe_rows[7] = '{FUNC_LOOKUP, 32'h7, 32'h0, 32'h0, 1, STAT_NO_MORE};
        probe_rows[8] = '{FUNC_INSERT, 32'hFFFFFC00, 32'h80000000, 32'h7FFFFFFF, 0,
                          STAT_INSERTED};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_rows[i]) begin
            send_word(probe_rows[i].func, probe_rows[i].hash, probe_rows[i].key,
                      probe_rows[i].payload);
            if (probe_rows[i].typed) begin
                hash_table_apply(probe_rows[i].func, probe_rows[i].hash, probe_rows[i].key,
                                 probe_rows[i].payload);
                void'(pending_results.pop_back());
                push_result(probe_rows[i].status, 32'd0, 1'b1, 1'b0);
            end else begin
                hash_table_apply(probe_rows[i].func, probe_rows[i].hash, probe_rows[i].key,
                                 probe_rows[i].payload);
            end
        end

        // A long chain of equal keys cuts the lookup output at the cap.
        write_register(CFG_MULTI_MATCH, 4'd1);
        write_register(CFG_LOG_BUCKETS, 4'd2);
        for (int i = 0; i < 70; i++) begin
            send_checked(FUNC_INSERT, 32'h5, 32'hABCD, $urandom);
        end
        send_checked(FUNC_LOOKUP, 32'h5, 32'hABCD, 32'h0);
        send_checked(FUNC_LOOKUP, 32'h1, 32'h0, 32'h0);

        write_register(CFG_SPARE_A, 4'hF);
        write_register(CFG_LOG_BUCKETS, 4'd3);
        random_traffic(100);

        idle_pct = 76;
        write_register(CFG_MULTI_MATCH, 4'd0);
        write_register(CFG_LOG_BUCKETS, 4'd1);
        random_traffic(100);

        idle_pct  = 0;
        stall_pct = 76;
        write_register(CFG_SPARE_B, 4'h0);
        write_register(CFG_MULTI_MATCH, 4'd1);
        write_register(CFG_LOG_BUCKETS, 4'd15);
        random_traffic(100);

        idle_pct  = 23;
        stall_pct = 23;
        write_register(CFG_LOG_BUCKETS, 4'd0);
        random_traffic(50);
        write_register(CFG_LOG_BUCKETS, 4'd10);
        random_traffic(50);

        // Fill the overflow area and push past it.
        idle_pct  = 0;
        stall_pct = 0;
        write_register(CFG_MULTI_MATCH, 4'd0);
        write_register(CFG_LOG_BUCKETS, 4'd1);
        while (overflow_used < OVERFLOW_DEPTH) begin
            send_checked(FUNC_INSERT, 32'h0, $urandom, $urandom);
        end
        for (int i = 0; i < 3; i++) begin
            send_checked(FUNC_INSERT, $urandom, $urandom, $urandom);
        end
        send_checked(FUNC_LOOKUP, 32'h0, known_keys[known_keys.size() - 10], 32'h0);
        send_checked(FUNC_LOOKUP, 32'h2, 32'h12345678, 32'h0);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> chained_hash_table_engine.f
+incdir+rtl/core
rtl/core/chte_pkg.sv
rtl/core/chte_ram.sv
rtl/core/chained_hash_table_engine.sv
test/chained_hash_table_engine_test.sv
